### hw/rtl/scaled_decimal_magnitude_compare_top_macros.svh
// assertion macros for the scaled decimal magnitude compare block
// used by the port checker, no other dependencies
`ifndef SCALED_DECIMAL_MAGNITUDE_COMPARE_TOP_MACROS_SVH
`define SCALED_DECIMAL_MAGNITUDE_COMPARE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define SDMC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SDMC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sdmc_pkg.sv
// shared constants and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps

package sdmc_pkg;

  // port widths fixed by the operand format
  localparam int unsigned MANT_LO_W  = 64;
  localparam int unsigned MANT_HI_W  = 32;
  localparam int unsigned SCALE_IN_W = 5;

  // default configuration
  localparam int unsigned DEFAULT_MANTISSA_WIDTH = 96;
  localparam int unsigned DEFAULT_SCALE_WIDTH    = 5;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic cmp;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_zero;
  } dp_stat_t;

endpackage

### hw/rtl/scaled_decimal_magnitude_compare_top.sv
// top level of the scaled decimal magnitude compare block
// depends on sdmc_pkg, sdmc_ctrl and sdmc_datapath
`timescale 1ns / 1ps

// A transaction is taken when start_i is high and busy_o is low. The operand
// with the smaller scale is multiplied by ten once per cycle in the datapath,
// once per unit of scale difference, and then compared; done_o rises with the
// registered flags. done_o is high for a single cycle and the flags hold until
// the next compare; the receiver cannot stall, so it must take them in that
// cycle. A new transaction may be started in the same cycle that done_o is high.
module scaled_decimal_magnitude_compare_top #(
  parameter int unsigned MANTISSA_WIDTH = sdmc_pkg::DEFAULT_MANTISSA_WIDTH,
  parameter int unsigned SCALE_WIDTH    = sdmc_pkg::DEFAULT_SCALE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [sdmc_pkg::MANT_LO_W-1:0]  a_mant_lo_i,
  input  logic [sdmc_pkg::MANT_HI_W-1:0]  a_mant_hi_i,
  input  logic [sdmc_pkg::SCALE_IN_W-1:0] a_scale_i,
  input  logic [sdmc_pkg::MANT_LO_W-1:0]  b_mant_lo_i,
  input  logic [sdmc_pkg::MANT_HI_W-1:0]  b_mant_hi_i,
  input  logic [sdmc_pkg::SCALE_IN_W-1:0] b_scale_i,
  output logic                            done_o,
  output logic                            is_less_o,
  output logic                            is_greater_o,
  output logic                            is_equal_o
);
  import sdmc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  sdmc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  // datapath
  sdmc_datapath #(
    .MANTISSA_WIDTH (MANTISSA_WIDTH),
    .SCALE_WIDTH    (SCALE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .a_mant_lo_i  (a_mant_lo_i),
    .a_mant_hi_i  (a_mant_hi_i),
    .a_scale_i    (a_scale_i),
    .b_mant_lo_i  (b_mant_lo_i),
    .b_mant_hi_i  (b_mant_hi_i),
    .b_scale_i    (b_scale_i),
    .is_less_o    (is_less_o),
    .is_greater_o (is_greater_o),
    .is_equal_o   (is_equal_o)
  );

endmodule

### hw/rtl/sdmc_datapath.sv
// operand registers, multiply-by-ten unit and final magnitude compare
// depends on sdmc_pkg
`timescale 1ns / 1ps

module sdmc_datapath #(
  parameter int unsigned MANTISSA_WIDTH = sdmc_pkg::DEFAULT_MANTISSA_WIDTH,
  parameter int unsigned SCALE_WIDTH    = sdmc_pkg::DEFAULT_SCALE_WIDTH
) (
  input  logic                              clk_i,
  input  sdmc_pkg::dp_cmd_t                 cmd_i,
  output sdmc_pkg::dp_stat_t                stat_o,
  input  logic [sdmc_pkg::MANT_LO_W-1:0]    a_mant_lo_i,
  input  logic [sdmc_pkg::MANT_HI_W-1:0]    a_mant_hi_i,
  input  logic [sdmc_pkg::SCALE_IN_W-1:0]   a_scale_i,
  input  logic [sdmc_pkg::MANT_LO_W-1:0]    b_mant_lo_i,
  input  logic [sdmc_pkg::MANT_HI_W-1:0]    b_mant_hi_i,
  input  logic [sdmc_pkg::SCALE_IN_W-1:0]   b_scale_i,
  output logic                              is_less_o,
  output logic                              is_greater_o,
  output logic                              is_equal_o
);
  import sdmc_pkg::*;

  // four bits of growth per scale step cover a factor of ten
  localparam int unsigned WIDE_W = MANTISSA_WIDTH + 4 * ((1 << SCALE_WIDTH) - 1);

  logic [MANTISSA_WIDTH-1:0] a_mant, b_mant;
  logic [SCALE_WIDTH-1:0]    a_sc, b_sc;
  logic                      a_smaller;

  logic [WIDE_W-1:0]         x_q, x_d;
  logic [MANTISSA_WIDTH-1:0] y_q, y_d;
  logic [SCALE_WIDTH-1:0]    cnt_q, cnt_d;
  logic                      a_is_x_q, a_is_x_d;
  logic                      less_q, less_d;
  logic                      greater_q, greater_d;
  logic                      equal_q, equal_d;

  logic [WIDE_W-1:0]         y_wide;
  logic                      x_lt, x_eq;

  // drop mantissa and scale bits beyond the configured widths
  assign a_mant    = MANTISSA_WIDTH'({a_mant_hi_i, a_mant_lo_i});
  assign b_mant    = MANTISSA_WIDTH'({b_mant_hi_i, b_mant_lo_i});
  assign a_sc      = SCALE_WIDTH'(a_scale_i);
  assign b_sc      = SCALE_WIDTH'(b_scale_i);
  assign a_smaller = (a_sc < b_sc);

  // aligned compare of the multiplied operand against the other one
  assign y_wide = WIDE_W'(y_q);
  assign x_lt   = (x_q < y_wide);
  assign x_eq   = (x_q == y_wide);

  // next values of the operand registers
  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    cnt_d     = cnt_q;
    a_is_x_d  = a_is_x_q;
    less_d    = less_q;
    greater_d = greater_q;
    equal_d   = equal_q;
    if (cmd_i.load) begin
      // the operand with the smaller scale gets multiplied
      if (a_smaller) begin
        x_d      = WIDE_W'(a_mant);
        y_d      = b_mant;
        cnt_d    = b_sc - a_sc;
        a_is_x_d = 1'b1;
      end else begin
        x_d      = WIDE_W'(b_mant);
        y_d      = a_mant;
        cnt_d    = a_sc - b_sc;
        a_is_x_d = 1'b0;
      end
    end else if (cmd_i.step) begin
      // times ten as shift by three plus shift by one
      x_d   = (x_q << 3) + (x_q << 1);
      cnt_d = cnt_q - 1'b1;
    end else if (cmd_i.cmp) begin
      equal_d = x_eq;
      if (a_is_x_q) begin
        less_d    = x_lt;
        greater_d = !x_lt && !x_eq;
      end else begin
        less_d    = !x_lt && !x_eq;
        greater_d = x_lt;
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    cnt_q     <= cnt_d;
    a_is_x_q  <= a_is_x_d;
    less_q    <= less_d;
    greater_q <= greater_d;
    equal_q   <= equal_d;
  end

  assign stat_o.cnt_zero = (cnt_q == '0);
  assign is_less_o       = less_q;
  assign is_greater_o    = greater_q;
  assign is_equal_o      = equal_q;

endmodule

### hw/rtl/sdmc_ctrl.sv
// sequencing state machine for load, alignment steps and compare
// depends on sdmc_pkg
`timescale 1ns / 1ps

module sdmc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  output sdmc_pkg::dp_cmd_t  cmd_o,
  input  sdmc_pkg::dp_stat_t stat_i
);
  import sdmc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_ALIGN
  } state_e;

  state_e state_q;
  logic   done_q;

  // commands to the datapath
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_ALIGN: begin
        cmd_o.step = !stat_i.cnt_zero;
        cmd_o.cmp  = stat_i.cnt_zero;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (stat_i.cnt_zero) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q == ST_ALIGN);
  assign done_o = done_q;

endmodule

### hw/rtl/sdmc_checker.sv
// port-level checker for the compare block, bound to the top level
// depends on scaled_decimal_magnitude_compare_top_macros.svh
`timescale 1ns / 1ps
`include "scaled_decimal_magnitude_compare_top_macros.svh"

module sdmc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic is_less_o,
  input logic is_greater_o,
  input logic is_equal_o
);

  // exactly one flag with each result
  `SDMC_ASSERT_NOW(a_flags_onehot, clk_i, rst_ni, done_o, $onehot({is_less_o, is_greater_o, is_equal_o}), "result flags not one-hot")

  // an accepted transaction makes the block busy
  `SDMC_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_o, busy_o, "not busy after accepted transaction")

  // the result strobe is never high twice in a row
  `SDMC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe held for two cycles")

  // busy only ends with a result
  `SDMC_ASSERT_NOW(a_done_on_idle, clk_i, rst_ni, $fell(busy_o), done_o, "busy dropped without a result")

endmodule

bind scaled_decimal_magnitude_compare_top sdmc_checker u_sdmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .is_less_o    (is_less_o),
  .is_greater_o (is_greater_o),
  .is_equal_o   (is_equal_o)
);
